// File: rtl/sb_pkg.sv
// Shared types, constants and helpers for the seam backtracking block.
package sb_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int STORE_DEPTH  = 4096;
    localparam int STORE_AW     = 12;
    localparam int OUTQ_DEPTH   = 4;
    localparam int PADDR_W      = 4;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_COLS      = 2'd2;

    typedef struct packed {
        logic [31:0] cost;
        logic        last_entry;
    } t_item;

    typedef struct packed {
        logic [5:0] seam_index;
        logic [5:0] step_index;
        logic       last_of_seam;
    } t_result;

    // job handed from the loader to the backtrack engine
    typedef struct packed {
        logic       vld;
        logic       dir;
        logic [6:0] len;
        logic [6:0] span;
        logic [6:0] cols;
    } t_job;

    typedef struct packed {
        logic take;
        logic busy;
    } t_back_stat;

    // store address of walk step s, choice position p
    function automatic logic [STORE_AW-1:0] f_addr(input logic dir, input logic [5:0] s,
                                                   input logic [5:0] p,
                                                   input logic [6:0] cols);
        logic [5:0]  major;
        logic [5:0]  minor;
        logic [12:0] sum;
        major = dir ? p : s;
        minor = dir ? s : p;
        sum   = {7'd0, major} * {6'd0, cols} + {7'd0, minor};
        return sum[STORE_AW-1:0];
    endfunction

endpackage

// File: rtl/sb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sb_front.sv
// Loader: takes map entries into the store and posts a backtrack job on the last one.
module sb_front #(
    parameter int MAX_ROWS = sb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = sb_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  sb_pkg::t_item               i_item,
    output logic                        o_full,
    input  logic                        i_dir,
    input  logic [6:0]                  i_rows,
    input  logic [6:0]                  i_cols,
    output logic                        o_ram_we,
    output logic [sb_pkg::STORE_AW-1:0] o_ram_waddr,
    output logic [31:0]                 o_ram_wdata,
    output sb_pkg::t_job                o_job,
    input  sb_pkg::t_back_stat          i_stat
);

    logic [sb_pkg::STORE_AW-1:0] r_load_count;
    sb_pkg::t_job                r_job;
    logic                        accept;
    logic [6:0]                  rows_eff;
    logic [6:0]                  cols_eff;

    always_comb begin
        rows_eff = i_rows;
        if (i_rows == 7'd0) begin
            rows_eff = 7'd1;
        end else if (i_rows > 7'(MAX_ROWS)) begin
            rows_eff = 7'(MAX_ROWS);
        end
        cols_eff = i_cols;
        if (i_cols == 7'd0) begin
            cols_eff = 7'd1;
        end else if (i_cols > 7'(MAX_COLS)) begin
            cols_eff = 7'(MAX_COLS);
        end
    end

    // hold off loading while a job waits or the engine is busy
    assign o_full      = r_job.vld | i_stat.busy;
    assign accept      = i_push & ~o_full;
    assign o_ram_we    = accept;
    assign o_ram_waddr = r_load_count;
    assign o_ram_wdata = i_item.cost;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_job.vld    <= 1'b0;
        end else begin
            if (accept) begin
                r_load_count <= i_item.last_entry ? '0 : r_load_count + 1'b1;
            end
            if (accept && i_item.last_entry) begin
                r_job.vld <= 1'b1;
            end else if (i_stat.take) begin
                r_job.vld <= 1'b0;
            end
        end
        if (accept && i_item.last_entry) begin
            r_job.dir  <= i_dir;
            r_job.len  <= i_dir ? cols_eff : rows_eff;
            r_job.span <= i_dir ? rows_eff : cols_eff;
            r_job.cols <= cols_eff;
        end
    end

endmodule

// File: rtl/sb_back.sv
// Backtrack engine: argmin over the final line, then the neighbor walk.
module sb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sb_pkg::t_job                i_job,
    output sb_pkg::t_back_stat          o_stat,
    output logic                        o_ram_re,
    output logic [sb_pkg::STORE_AW-1:0] o_ram_raddr,
    input  logic [31:0]                 i_ram_rdata,
    output logic                        o_res_push,
    output sb_pkg::t_result             o_res,
    input  logic                        i_res_full
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_SCAN_END = 8'b0000_0100,
        S_EMIT     = 8'b0000_1000,
        S_RD_C     = 8'b0001_0000,
        S_RD_L     = 8'b0010_0000,
        S_RD_R     = 8'b0100_0000,
        S_DECIDE   = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic        r_dir;
    logic [5:0]  r_len_m1;
    logic [6:0]  r_span;
    logic [6:0]  r_cols;
    logic [5:0]  r_k;
    logic        r_tag_vld;
    logic [5:0]  r_tag_k;
    logic [31:0] r_best;
    logic [5:0]  r_pos;
    logic [5:0]  r_s;
    logic [31:0] r_c;
    logic [31:0] r_l;

    logic [5:0]  lp;
    logic [5:0]  rp;
    logic [6:0]  pos_p1;
    logic [6:0]  span_m1;
    logic [5:0]  s_m1;
    logic [31:0] mlc;
    logic [31:0] mrc;
    logic        scan_last;

    assign pos_p1    = {1'b0, r_pos} + 7'd1;
    assign span_m1   = r_span - 7'd1;
    assign lp        = (r_pos != 6'd0) ? r_pos - 6'd1 : 6'd0;
    assign rp        = (pos_p1 < r_span) ? pos_p1[5:0] : span_m1[5:0];
    assign s_m1      = r_s - 6'd1;
    assign scan_last = ({1'b0, r_k} == span_m1);
    assign mlc       = (r_l < r_c) ? r_l : r_c;
    assign mrc       = (i_ram_rdata < r_c) ? i_ram_rdata : r_c;

    assign o_stat.take = (r_state == S_IDLE) & i_job.vld;
    assign o_stat.busy = (r_state != S_IDLE);

    assign o_res.seam_index   = r_pos;
    assign o_res.step_index   = r_s;
    assign o_res.last_of_seam = (r_s == 6'd0);

    always_comb begin
        n_state     = r_state;
        o_ram_re    = 1'b0;
        o_ram_raddr = sb_pkg::f_addr(r_dir, s_m1, r_pos, r_cols);
        o_res_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job.vld) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = sb_pkg::f_addr(r_dir, r_len_m1, r_k, r_cols);
                if (scan_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = (r_s == 6'd0) ? S_IDLE : S_RD_C;
                end
            end
            S_RD_C: begin
                o_ram_re = 1'b1;
                n_state  = S_RD_L;
            end
            S_RD_L: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = sb_pkg::f_addr(r_dir, s_m1, lp, r_cols);
                n_state     = S_RD_R;
            end
            S_RD_R: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = sb_pkg::f_addr(r_dir, s_m1, rp, r_cols);
                n_state     = S_DECIDE;
            end
            S_DECIDE: n_state = S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tag_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tag_vld <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job.vld) begin
            r_dir    <= i_job.dir;
            r_len_m1 <= 6'(i_job.len - 7'd1);
            r_span   <= i_job.span;
            r_cols   <= i_job.cols;
            r_k      <= '0;
        end
        if (r_state == S_SCAN && !scan_last) begin
            r_k <= r_k + 6'd1;
        end
        r_tag_k <= r_k;
        // read data arrives in the cycle after its address; ties keep the lower index
        if (r_tag_vld && (r_tag_k == 6'd0 || i_ram_rdata < r_best)) begin
            r_best <= i_ram_rdata;
            r_pos  <= r_tag_k;
        end
        if (r_state == S_SCAN_END) begin
            r_s <= r_len_m1;
        end
        if (r_state == S_RD_L) begin
            r_c <= i_ram_rdata;
        end
        if (r_state == S_RD_R) begin
            r_l <= i_ram_rdata;
        end
        if (r_state == S_DECIDE) begin
            if (mlc > i_ram_rdata) begin
                r_pos <= rp;
            end else if (mrc > r_l) begin
                r_pos <= lp;
            end
            r_s <= s_m1;
        end
    end

endmodule

// File: rtl/sb_outq.sv
// Small result queue between the backtrack engine and the result port.
module sb_outq #(
    parameter int DEPTH = sb_pkg::OUTQ_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sb_pkg::t_result i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sb_pkg::t_result o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sb_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/seam_backtrack.sv
// Seam backtracking over a streamed cumulative-energy map.
//
// Input queue (push/full): map entries in row-major order, one per cycle
// while full is low. Each entry lands in a 4096 x 32 store. The entry flagged
// last_entry starts a backtrack job; full rises on the next cycle and stays
// high until the engine has produced every seam entry into its result queue.
// Backtrack: an argmin scan over the final row (column in horizontal mode)
// reads one store word per cycle, then each walk step reads center, left and
// right neighbors through the single store read port.
// Result queue (empty/pop): one seam entry per step, last row/column first,
// last_of_seam on the entry for row or column zero. A stalled receiver fills
// the 4-entry result queue and holds the engine; loading resumes only after
// the engine finishes.
// Reset clears the load address, job and queues; config returns to vertical
// mode, 64 x 64. The store is not cleared. Config is written over the APB port
// at byte address 4*i and should only change while the block is idle.
module seam_backtrack #(
    parameter int MAX_ROWS = sb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = sb_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    input  sb_pkg::t_item              i_item,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output sb_pkg::t_result            o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                        r_dir;
    logic [6:0]                  r_rows;
    logic [6:0]                  r_cols;
    logic                        cfg_wr;
    logic                        ram_we;
    logic [sb_pkg::STORE_AW-1:0] ram_waddr;
    logic [31:0]                 ram_wdata;
    logic                        ram_re;
    logic [sb_pkg::STORE_AW-1:0] ram_raddr;
    logic [31:0]                 ram_rdata;
    sb_pkg::t_job                job;
    sb_pkg::t_back_stat          stat;
    logic                        res_push;
    sb_pkg::t_result             res;
    logic                        res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sb_pkg::REG_DIRECTION: r_dir  <= pwdata[0];
                sb_pkg::REG_ROWS:      r_rows <= pwdata[6:0];
                sb_pkg::REG_COLS:      r_cols <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sb_pkg::REG_DIRECTION: prdata = {31'd0, r_dir};
            sb_pkg::REG_ROWS:      prdata = {25'd0, r_rows};
            sb_pkg::REG_COLS:      prdata = {25'd0, r_cols};
            default:               prdata = '0;
        endcase
    end

    sb_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_dir       (r_dir),
        .i_rows      (r_rows),
        .i_cols      (r_cols),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_job       (job),
        .i_stat      (stat)
    );

    sb_ram #(
        .WIDTH (32),
        .DEPTH (sb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .o_stat      (stat),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    sb_outq #(
        .DEPTH (sb_pkg::OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

// File: rtl/sb_checker.sv
// Port-level checks for seam_backtrack, bound to the top level.
module sb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            push,
    input sb_pkg::t_item   i_item,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input sb_pkg::t_result o_result,
    input logic            pready
);

    // queue comes out of reset with nothing to deliver
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // accepting the last entry of a map must be followed by full, blocking loading
    a_full_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_item.last_entry) |=> full)
        else $error("input not held off after last map entry");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.last_of_seam == (o_result.step_index == 6'd0)))
        else $error("last_of_seam does not match step zero");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before transfer");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind seam_backtrack sb_checker u_sb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .i_item   (i_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result),
    .pready   (pready)
);
